>>> rtl/core/mprq_pkg.sv
// Shared field widths, operation codes and status codes of the priority ready queue.
package mprq_pkg;

	localparam int OP_W    = 3;
	localparam int CPU_W   = 2;
	localparam int TASK_W  = 6;
	localparam int PRIO_W  = 5;
	localparam int AFF_W   = 4;
	localparam int LAST_W  = 3;
	localparam int STAT_W  = 2;
	localparam int TOTAL_W = 7;

	localparam logic [OP_W-1:0] OP_ENQ_PICK = 3'd0;
	localparam logic [OP_W-1:0] OP_ENQ_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_ENQ_TAIL = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_TAKE_TOP = 3'd4;
	localparam logic [OP_W-1:0] OP_REPORT   = 3'd5;

	localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_QUEUED     = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NOT_QUEUED = 2'd2;

endpackage

>>> rtl/core/multicore_priority_ready_queue.sv
// Top level of the per-cpu priority ready queue with cpu affinity.
// Usage: one command word enters on the input channel (in_valid, in_stall) and
// exactly one result word leaves on the output channel (out_valid, out_stall).
// Commands are handled one at a time by a sequencer around synchronous
// memories, each with one write port and one read port, for list heads, tails, links and task attributes.
// Steps from acceptance to a registered result word: a report or unused code
// goes straight to the result; an enqueue writes an empty list at once, links
// into a populated one in a link and a fix step, and reads back the cpu of a
// queued task; a remove checks, then unlinks; take top picks each nonempty
// priority, reads its head and walks its list, one memory read per task, ending
// in a last priority step when nothing is found. The next command is taken the
// cycle after the result is registered. The result sits in an output register;
// while the receiver stalls it holds, and the next command is still accepted
// and processed, waiting only at its own completion until the register frees.
// Reset clears all queues, flags and counters and marks every cpu busy; the
// link and attribute memories need no clearing, and commands are accepted
// immediately after reset.
module multicore_priority_ready_queue #(
	parameter int NUM_CPUS       = 4,
	parameter int NUM_PRIORITIES = 32,
	parameter int MAX_TASKS      = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mprq_pkg::OP_W-1:0]      operation,
	input  logic [mprq_pkg::CPU_W-1:0]     cpu,
	input  logic [mprq_pkg::TASK_W-1:0]    task_req,
	input  logic [mprq_pkg::PRIO_W-1:0]    priority_req,
	input  logic [mprq_pkg::AFF_W-1:0]     affinity,
	input  logic signed [mprq_pkg::LAST_W-1:0] last_cpu,
	input  logic                           is_idle,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mprq_pkg::CPU_W-1:0]     chosen_cpu,
	output logic                           found,
	output logic [mprq_pkg::TASK_W-1:0]    top_task,
	output logic [mprq_pkg::PRIO_W-1:0]    top_priority,
	output logic [mprq_pkg::STAT_W-1:0]    status,
	output logic [mprq_pkg::TOTAL_W-1:0]   ready_total
);

	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PW = $clog2(NUM_PRIORITIES);
	localparam int IW = $clog2(MAX_TASKS);
	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int QD = NUM_CPUS * NUM_PRIORITIES;
	localparam int QW = $clog2(QD);
	localparam logic [LW-1:0] NO_TASK = LW'(MAX_TASKS);

	typedef struct packed {
		logic [PW-1:0]                 prio;
		logic [mprq_pkg::AFF_W-1:0]    aff;
		logic [CW-1:0]                 cpu;
	} attr_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ENQ, S_ENQ_DUP, S_ENQ_LINK, S_ENQ_FIX, S_RM, S_RM_W,
		S_TT_PRIO, S_TT_HEAD, S_TT_CHECK, S_DONE
	} state_t;

	state_t state_q;

	logic [LW-1:0] head_mem [QD];
	logic [LW-1:0] tail_mem [QD];
	logic [LW-1:0] next_mem [MAX_TASKS];
	logic [LW-1:0] prev_mem [MAX_TASKS];
	attr_t         attr_mem [MAX_TASKS];

	logic [LW-1:0] head_rd, tail_rd, next_rd, prev_rd;
	attr_t         attr_rd;

	logic          head_we, tail_we, next_we, prev_we, attr_we;
	logic [QW-1:0] head_wa, tail_wa, hq_ra;
	logic [IW-1:0] next_wa, prev_wa, attr_wa, task_ra;
	logic [LW-1:0] head_wd, tail_wd, next_wd, prev_wd;
	attr_t         attr_wd;

	logic [NUM_CPUS-1:0][NUM_PRIORITIES-1:0] bitmap_q;
	logic [MAX_TASKS-1:0]                    queued_q;
	logic [NUM_CPUS-1:0]                     active_q;
	logic [LW-1:0]                           count_q [NUM_CPUS];

	logic [mprq_pkg::OP_W-1:0]   op_q;
	logic [CW-1:0]               cpu_q;
	logic                        task_ok_q;
	logic [IW-1:0]               t_q;
	logic [PW-1:0]               prio_q;
	logic [mprq_pkg::AFF_W-1:0]  aff_q;
	logic [mprq_pkg::LAST_W-1:0] last_q;
	logic [QW-1:0]               q_q;
	logic [PW-1:0]               p_q;
	logic [NUM_PRIORITIES-1:0]   done_q;

	logic [CW-1:0]                res_chosen_q;
	logic                         res_found_q;
	logic [IW-1:0]                res_top_q;
	logic [PW-1:0]                res_prio_q;
	logic [mprq_pkg::STAT_W-1:0]  res_status_q;

	logic                         out_valid_q;
	logic [mprq_pkg::CPU_W-1:0]   chosen_cpu_q;
	logic                         found_q;
	logic [mprq_pkg::TASK_W-1:0]  top_task_q;
	logic [mprq_pkg::PRIO_W-1:0]  top_priority_q;
	logic [mprq_pkg::STAT_W-1:0]  status_q;
	logic [mprq_pkg::TOTAL_W-1:0] ready_total_q;

	logic [CW-1:0]             picked;
	logic [CW-1:0]             enq_cpu;
	logic [QW-1:0]             enq_q;
	logic                      enq_bit;
	logic [CW-1:0]             in_cpu;
	logic [QW-1:0]             unl_q;
	logic                      match;
	logic [NUM_PRIORITIES-1:0] rem;
	logic [PW-1:0]             plow;
	logic                      accept;
	logic                      out_free;

	function automatic logic [QW-1:0] qidx(input logic [CW-1:0] c, input logic [PW-1:0] p);
		return QW'(32'(c) * NUM_PRIORITIES + 32'(p));
	endfunction

	mprq_pick_cpu #(.NUM_CPUS(NUM_CPUS)) u_pick (
		.affinity    (aff_q),
		.last_cpu    (last_q),
		.active_mask (active_q),
		.chosen      (picked)
	);

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		logic [2:0] c3;
		c3 = 3'(cpu);
		for (int i = 0; i < 3; i++) begin
			if (32'(c3) >= NUM_CPUS) begin
				c3 = 3'(32'(c3) - NUM_CPUS);
			end
		end
		in_cpu = CW'(c3);
	end

	always_comb begin
		enq_cpu = (op_q == mprq_pkg::OP_ENQ_PICK) ? picked : cpu_q;
		enq_q = qidx(enq_cpu, prio_q);
		enq_bit = bitmap_q[enq_cpu][prio_q];
		unl_q = qidx(attr_rd.cpu, attr_rd.prio);
		match = attr_rd.aff[2'(cpu_q)];
		rem = bitmap_q[cpu_q] & ~done_q;
		plow = '0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (rem[i]) begin
				plow = PW'(i);
			end
		end
	end

	always_comb begin
		head_we = 1'b0; tail_we = 1'b0; next_we = 1'b0; prev_we = 1'b0; attr_we = 1'b0;
		head_wa = '0; tail_wa = '0; next_wa = '0; prev_wa = '0; attr_wa = t_q;
		head_wd = '0; tail_wd = '0; next_wd = '0; prev_wd = '0;
		attr_wd = '{prio: prio_q, aff: aff_q, cpu: enq_cpu};
		hq_ra = enq_q;
		task_ra = t_q;
		case (state_q)
			S_ENQ: begin
				if (task_ok_q && !queued_q[t_q]) begin
					attr_we = 1'b1;
					if (!enq_bit) begin
						head_we = 1'b1; head_wa = enq_q; head_wd = LW'(t_q);
						tail_we = 1'b1; tail_wa = enq_q; tail_wd = LW'(t_q);
						next_we = 1'b1; next_wa = t_q;   next_wd = NO_TASK;
						prev_we = 1'b1; prev_wa = t_q;   prev_wd = NO_TASK;
					end
				end
			end
			S_ENQ_LINK: begin
				if (op_q == mprq_pkg::OP_ENQ_HEAD) begin
					next_we = 1'b1; next_wa = t_q;         next_wd = head_rd;
					prev_we = 1'b1; prev_wa = IW'(head_rd); prev_wd = LW'(t_q);
					head_we = 1'b1; head_wa = q_q;         head_wd = LW'(t_q);
				end else begin
					prev_we = 1'b1; prev_wa = t_q;         prev_wd = tail_rd;
					next_we = 1'b1; next_wa = IW'(tail_rd); next_wd = LW'(t_q);
					tail_we = 1'b1; tail_wa = q_q;         tail_wd = LW'(t_q);
				end
			end
			S_ENQ_FIX: begin
				if (op_q == mprq_pkg::OP_ENQ_HEAD) begin
					prev_we = 1'b1; prev_wa = t_q; prev_wd = NO_TASK;
				end else begin
					next_we = 1'b1; next_wa = t_q; next_wd = NO_TASK;
				end
			end
			S_RM_W, S_TT_CHECK: begin
				if (state_q == S_RM_W || match) begin
					if (prev_rd == NO_TASK) begin
						head_we = 1'b1; head_wa = unl_q; head_wd = next_rd;
					end else begin
						next_we = 1'b1; next_wa = IW'(prev_rd); next_wd = next_rd;
					end
					if (next_rd == NO_TASK) begin
						tail_we = 1'b1; tail_wa = unl_q; tail_wd = prev_rd;
					end else begin
						prev_we = 1'b1; prev_wa = IW'(next_rd); prev_wd = prev_rd;
					end
				end else begin
					task_ra = IW'(next_rd);
				end
			end
			S_TT_PRIO: begin
				hq_ra = qidx(cpu_q, plow);
			end
			S_TT_HEAD: begin
				task_ra = IW'(head_rd);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (attr_we) attr_mem[attr_wa] <= attr_wd;
		head_rd <= head_mem[hq_ra];
		tail_rd <= tail_mem[hq_ra];
		next_rd <= next_mem[task_ra];
		prev_rd <= prev_mem[task_ra];
		attr_rd <= attr_mem[task_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bitmap_q <= '0;
			queued_q <= '0;
			active_q <= '1;
			for (int i = 0; i < NUM_CPUS; i++) begin
				count_q[i] <= '0;
			end
			op_q <= '0; cpu_q <= '0; task_ok_q <= 1'b0; t_q <= '0; prio_q <= '0;
			aff_q <= '0; last_q <= '0; q_q <= '0; p_q <= '0; done_q <= '0;
			res_chosen_q <= '0; res_found_q <= 1'b0; res_top_q <= '0;
			res_prio_q <= '0; res_status_q <= mprq_pkg::STATUS_OK;
			out_valid_q <= 1'b0;
			chosen_cpu_q <= '0; found_q <= 1'b0; top_task_q <= '0;
			top_priority_q <= '0; status_q <= mprq_pkg::STATUS_OK; ready_total_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= operation;
						cpu_q <= in_cpu;
						task_ok_q <= (32'(task_req) < MAX_TASKS);
						t_q <= IW'(task_req);
						prio_q <= (32'(priority_req) >= NUM_PRIORITIES) ?
							PW'(NUM_PRIORITIES - 1) : PW'(priority_req);
						aff_q <= affinity;
						last_q <= last_cpu;
						done_q <= '0;
						res_chosen_q <= '0; res_found_q <= 1'b0; res_top_q <= '0;
						res_prio_q <= '0; res_status_q <= mprq_pkg::STATUS_OK;
						case (operation)
							mprq_pkg::OP_ENQ_PICK, mprq_pkg::OP_ENQ_HEAD,
							mprq_pkg::OP_ENQ_TAIL: state_q <= S_ENQ;
							mprq_pkg::OP_REMOVE:   state_q <= S_RM;
							mprq_pkg::OP_TAKE_TOP: state_q <= S_TT_PRIO;
							mprq_pkg::OP_REPORT: begin
								active_q[in_cpu] <= !is_idle;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ENQ: begin
					if (!task_ok_q) begin
						res_status_q <= mprq_pkg::STATUS_NOT_QUEUED;
						state_q <= S_DONE;
					end else if (queued_q[t_q]) begin
						res_status_q <= mprq_pkg::STATUS_QUEUED;
						state_q <= S_ENQ_DUP;
					end else begin
						res_chosen_q <= enq_cpu;
						q_q <= enq_q;
						queued_q[t_q] <= 1'b1;
						count_q[enq_cpu] <= count_q[enq_cpu] + 1'b1;
						if (!enq_bit) begin
							bitmap_q[enq_cpu][prio_q] <= 1'b1;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ENQ_LINK;
						end
					end
				end
				S_ENQ_DUP: begin
					res_chosen_q <= attr_rd.cpu;
					state_q <= S_DONE;
				end
				S_ENQ_LINK: state_q <= S_ENQ_FIX;
				S_ENQ_FIX:  state_q <= S_DONE;
				S_RM: begin
					if (!task_ok_q || !queued_q[t_q]) begin
						res_status_q <= mprq_pkg::STATUS_NOT_QUEUED;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RM_W;
					end
				end
				S_RM_W, S_TT_CHECK: begin
					if (state_q == S_RM_W || match) begin
						if (prev_rd == NO_TASK && next_rd == NO_TASK) begin
							bitmap_q[attr_rd.cpu][attr_rd.prio] <= 1'b0;
						end
						queued_q[t_q] <= 1'b0;
						count_q[attr_rd.cpu] <= count_q[attr_rd.cpu] - 1'b1;
						if (state_q == S_TT_CHECK) begin
							res_found_q <= 1'b1;
							res_top_q <= t_q;
							res_prio_q <= p_q;
						end
						state_q <= S_DONE;
					end else if (next_rd == NO_TASK) begin
						state_q <= S_TT_PRIO;
					end else begin
						t_q <= IW'(next_rd);
					end
				end
				S_TT_PRIO: begin
					if (rem == '0) begin
						state_q <= S_DONE;
					end else begin
						p_q <= plow;
						done_q[plow] <= 1'b1;
						state_q <= S_TT_HEAD;
					end
				end
				S_TT_HEAD: begin
					t_q <= IW'(head_rd);
					state_q <= S_TT_CHECK;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						chosen_cpu_q <= mprq_pkg::CPU_W'(res_chosen_q);
						found_q <= res_found_q;
						top_task_q <= mprq_pkg::TASK_W'(res_top_q);
						top_priority_q <= mprq_pkg::PRIO_W'(res_prio_q);
						status_q <= res_status_q;
						ready_total_q <= mprq_pkg::TOTAL_W'(count_q[cpu_q]);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign chosen_cpu   = chosen_cpu_q;
	assign found        = found_q;
	assign top_task     = top_task_q;
	assign top_priority = top_priority_q;
	assign status       = status_q;
	assign ready_total  = ready_total_q;

endmodule

>>> rtl/core/mprq_pick_cpu.sv
// Target cpu selection for an enqueue from affinity, last cpu and the idle mask.
module mprq_pick_cpu #(
	parameter int NUM_CPUS = 4,
	localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1
) (
	input  logic [mprq_pkg::AFF_W-1:0]  affinity,
	input  logic [mprq_pkg::LAST_W-1:0] last_cpu,
	input  logic [NUM_CPUS-1:0]         active_mask,
	output logic [CW-1:0]               chosen
);

	logic [NUM_CPUS-1:0] aff;
	logic [NUM_CPUS-1:0] aff_rest;
	logic [NUM_CPUS-1:0] idle;
	logic [CW-1:0]       first;
	logic [CW-1:0]       low_idle;
	logic                last_ok;
	logic                single;

	always_comb begin
		aff = NUM_CPUS'(affinity);
		idle = ~active_mask;
		first = '0;
		low_idle = '0;
		for (int i = NUM_CPUS - 1; i >= 0; i--) begin
			if (aff[i]) begin
				first = CW'(i);
			end
			if (idle[i]) begin
				low_idle = CW'(i);
			end
		end
		aff_rest = aff;
		aff_rest[first] = 1'b0;
		single = (aff_rest == '0);
		last_ok = !last_cpu[mprq_pkg::LAST_W-1] && (32'(last_cpu) < NUM_CPUS);
		if (single) begin
			chosen = first;
		end else if (idle != '0) begin
			if (last_ok && idle[CW'(last_cpu)]) begin
				chosen = CW'(last_cpu);
			end else begin
				chosen = low_idle;
			end
		end else begin
			chosen = '0;
		end
	end

endmodule

>>> rtl/core/mprq_checker.sv
// Port-level assertions for the priority ready queue and their bind.
module mprq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mprq_pkg::CPU_W-1:0]     chosen_cpu,
	input logic                           found,
	input logic [mprq_pkg::TASK_W-1:0]    top_task,
	input logic [mprq_pkg::PRIO_W-1:0]    top_priority,
	input logic [mprq_pkg::STAT_W-1:0]    status,
	input logic [mprq_pkg::TOTAL_W-1:0]   ready_total
);

	// Every accepted word occupies the sequencer, which stalls the input after each acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(top_task)
			&& $stable(status) && $stable(ready_total) && $stable(chosen_cpu))
		else $error("stalled result word changed");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == mprq_pkg::STATUS_OK && chosen_cpu == '0)
		else $error("taken task reported with a nonzero status or cpu");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> top_task == '0 && top_priority == '0)
		else $error("task fields set without a taken task");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("status word out of range");

endmodule

bind multicore_priority_ready_queue mprq_checker u_mprq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.chosen_cpu   (chosen_cpu),
	.found        (found),
	.top_task     (top_task),
	.top_priority (top_priority),
	.status       (status),
	.ready_total  (ready_total)
);

>>> test/tb_multicore_priority_ready_queue.sv
// Testbench for the per-cpu priority ready queue with random and directed command words.
`timescale 1ns / 1ps

module tb_multicore_priority_ready_queue;

	localparam int NCPU = 4;
	localparam int NPRI = 32;
	localparam int NTSK = 64;
	localparam logic [6:0] NO_TASK = 7'd64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [mprq_pkg::CPU_W-1:0]   chosen_cpu;
		logic                         found;
		logic [mprq_pkg::TASK_W-1:0]  top_task;
		logic [mprq_pkg::PRIO_W-1:0]  top_priority;
		logic [mprq_pkg::STAT_W-1:0]  status;
		logic [mprq_pkg::TOTAL_W-1:0] ready_total;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [mprq_pkg::OP_W-1:0] operation = '0;
	logic [mprq_pkg::CPU_W-1:0] cpu = '0;
	logic [mprq_pkg::TASK_W-1:0] task_req = '0;
	logic [mprq_pkg::PRIO_W-1:0] priority_req = '0;
	logic [mprq_pkg::AFF_W-1:0] affinity = '0;
	logic signed [mprq_pkg::LAST_W-1:0] last_cpu = '0;
	logic is_idle = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [mprq_pkg::CPU_W-1:0] chosen_cpu;
	logic found;
	logic [mprq_pkg::TASK_W-1:0] top_task;
	logic [mprq_pkg::PRIO_W-1:0] top_priority;
	logic [mprq_pkg::STAT_W-1:0] status;
	logic [mprq_pkg::TOTAL_W-1:0] ready_total;

	multicore_priority_ready_queue DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [6:0] q_head [NCPU*NPRI];
	logic [6:0] q_tail [NCPU*NPRI];
	logic [6:0] nxt [NTSK];
	logic [6:0] prv [NTSK];
	logic [4:0] t_prio [NTSK];
	logic [3:0] t_aff [NTSK];
	logic [1:0] t_cpu [NTSK];
	logic t_queued [NTSK];
	logic [31:0] bitmap [NCPU];
	logic [3:0] busy_mask;
	int unsigned count [NCPU];

	result_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	bit idling = 1'b1;

	function automatic int lowest_set(logic [31:0] m);
		for (int i = 0; i < 32; i++)
			if (m[i])
				return i;
		return 0;
	endfunction

	task automatic clear_model();
		for (int i = 0; i < NCPU*NPRI; i++) begin
			q_head[i] = NO_TASK;
			q_tail[i] = NO_TASK;
		end
		for (int i = 0; i < NTSK; i++) begin
			nxt[i] = '0;
			prv[i] = '0;
			t_prio[i] = '0;
			t_aff[i] = '0;
			t_cpu[i] = '0;
			t_queued[i] = 1'b0;
		end
		for (int i = 0; i < NCPU; i++) begin
			bitmap[i] = '0;
			count[i] = 0;
		end
		busy_mask = 4'hf;
	endtask

	task automatic link_task(int c, int p, int t, bit at_head);
		int q;
		int h;
		q = c*NPRI + p;
		if (!bitmap[c][p]) begin
			q_head[q] = 7'(t);
			q_tail[q] = 7'(t);
			nxt[t] = NO_TASK;
			prv[t] = NO_TASK;
			bitmap[c][p] = 1'b1;
		end else if (at_head) begin
			h = int'(q_head[q]);
			nxt[t] = 7'(h);
			prv[t] = NO_TASK;
			prv[h] = 7'(t);
			q_head[q] = 7'(t);
		end else begin
			h = int'(q_tail[q]);
			prv[t] = 7'(h);
			nxt[t] = NO_TASK;
			nxt[h] = 7'(t);
			q_tail[q] = 7'(t);
		end
		t_cpu[t] = 2'(c);
		t_queued[t] = 1'b1;
		count[c]++;
	endtask

	task automatic unlink_task(int t);
		int c;
		int p;
		int q;
		logic [6:0] pv;
		logic [6:0] nx;
		c = int'(t_cpu[t]);
		p = int'(t_prio[t]);
		q = c*NPRI + p;
		pv = prv[t];
		nx = nxt[t];
		if (pv == NO_TASK) q_head[q] = nx; else nxt[pv] = nx;
		if (nx == NO_TASK) q_tail[q] = pv; else prv[nx] = pv;
		if (pv == NO_TASK && nx == NO_TASK)
			bitmap[c][p] = 1'b0;
		t_queued[t] = 1'b0;
		count[c]--;
	endtask

	function automatic int pick_target(logic [3:0] aff, logic [2:0] last);
		logic [3:0] idle_cpus;
		logic [3:0] last_bit;
		int first;
		idle_cpus = ~busy_mask;
		first = lowest_set(32'(aff));
		last_bit = (last < 3'd4) ? (4'b1 << last) : 4'b0;
		if ((aff & ~(4'b1 << first)) == 4'b0)
			return first;
		if (idle_cpus != 4'b0) begin
			if ((idle_cpus & last_bit) != 4'b0)
				return int'(last);
			return lowest_set(32'(idle_cpus));
		end
		return 0;
	endfunction

	task automatic predict_word(output result_t r);
		int c;
		int t;
		int g;
		r = '0;
		c = int'(cpu);
		if (operation inside {mprq_pkg::OP_ENQ_PICK, mprq_pkg::OP_ENQ_HEAD,
			mprq_pkg::OP_ENQ_TAIL}) begin
			if (t_queued[task_req]) begin
				r.status = mprq_pkg::STATUS_QUEUED;
				r.chosen_cpu = t_cpu[task_req];
			end else begin
				if (operation == mprq_pkg::OP_ENQ_PICK)
					r.chosen_cpu = 2'(pick_target(affinity, last_cpu));
				else
					r.chosen_cpu = cpu;
				t_prio[task_req] = priority_req;
				t_aff[task_req] = affinity;
				link_task(int'(r.chosen_cpu), int'(priority_req), int'(task_req),
					operation == mprq_pkg::OP_ENQ_HEAD);
			end
		end else if (operation == mprq_pkg::OP_REMOVE) begin
			if (t_queued[task_req]) unlink_task(int'(task_req));
			else r.status = mprq_pkg::STATUS_NOT_QUEUED;
		end else if (operation == mprq_pkg::OP_TAKE_TOP) begin
			for (int p = 0; p < NPRI && !r.found; p++) begin
				if (!bitmap[c][p])
					continue;
				t = int'(q_head[c*NPRI + p]);
				for (g = 0; t < NTSK && g < NTSK; g++) begin
					if (t_aff[t][c]) begin
						r.found = 1'b1;
						r.top_task = 6'(t);
						r.top_priority = 5'(p);
						unlink_task(t);
						break;
					end
					t = int'(nxt[t]);
				end
			end
		end else if (operation == mprq_pkg::OP_REPORT) begin
			busy_mask[c] = !is_idle;
		end
		r.ready_total = 7'(count[c]);
	endtask

	task automatic send_word(logic [2:0] op, logic [1:0] c, logic [5:0] t, logic [4:0] p,
		logic [3:0] a, logic [2:0] l, logic i);
		result_t r;
		@(negedge clk);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		operation <= op;
		cpu <= c;
		task_req <= t;
		priority_req <= p;
		affinity <= a;
		last_cpu <= l;
		is_idle <= i;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_word(r);
		expected_results.push_back(r);
	endtask

	task automatic send_random_word(bit well_formed);
		logic [2:0] op;
		int k;
		k = int'($urandom_range(0, 99));
		if (!well_formed) op = 3'($urandom);
		else if (k < 40) op = 3'($urandom_range(0, 2));
		else if (k < 55) op = mprq_pkg::OP_REMOVE;
		else if (k < 85) op = mprq_pkg::OP_TAKE_TOP;
		else op = mprq_pkg::OP_REPORT;
		send_word(op, 2'($urandom), 6'($urandom_range(0, 63)), 5'($urandom),
			4'($urandom), 3'($urandom), 1'($urandom));
	endtask

	task automatic test_directed();
		send_word(mprq_pkg::OP_TAKE_TOP, 2'd0, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_REMOVE, 2'd1, 6'd63, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd1, 5'd31, 4'h4, 3'd7, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd2, 5'd0, 4'h0, 3'd3, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd3, 6'd3, 5'd5, 4'hf, 3'd2, 1'b0);
		send_word(mprq_pkg::OP_REPORT, 2'd2, 6'd0, 5'd0, 4'h0, 3'd0, 1'b1);
		send_word(mprq_pkg::OP_REPORT, 2'd3, 6'd0, 5'd0, 4'h0, 3'd0, 1'b1);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd4, 5'd5, 4'hf, 3'd3, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd5, 5'd5, 4'hf, 3'd1, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd6, 5'd5, 4'hf, 3'd4, 1'b0);
		send_word(mprq_pkg::OP_ENQ_PICK, 2'd0, 6'd4, 5'd9, 4'h1, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_ENQ_TAIL, 2'd1, 6'd7, 5'd3, 4'h1, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_ENQ_TAIL, 2'd1, 6'd8, 5'd3, 4'h2, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_ENQ_HEAD, 2'd1, 6'd9, 5'd3, 4'h2, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_TAKE_TOP, 2'd1, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_TAKE_TOP, 2'd1, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_TAKE_TOP, 2'd1, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_REMOVE, 2'd0, 6'd7, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_TAKE_TOP, 2'd0, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(3'd6, 2'd2, 6'd63, 5'd31, 4'hf, 3'd7, 1'b1);
		send_word(3'd7, 2'd3, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_REPORT, 2'd2, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
		send_word(mprq_pkg::OP_REPORT, 2'd3, 6'd0, 5'd0, 4'h0, 3'd0, 1'b0);
	endtask

	task automatic test_random();
		for (int n = 0; n < 1000; n++)
			send_random_word($urandom_range(0, 9) != 0);
	endtask

	task automatic test_no_idling();
		idling = 1'b0;
		for (int n = 0; n < 130; n++)
			send_random_word(1'b1);
	endtask

	always @(negedge clk) begin
		static int burst = 0;
		if (burst > 0) begin
			burst--;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			burst = int'($urandom_range(0, 8));
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		result_t e;
		result_t a;
		if (arst_n && out_valid && !out_stall) begin
			a = '{chosen_cpu, found, top_task, top_priority, status, ready_total};
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, a);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (e.chosen_cpu != a.chosen_cpu)
					$display("%0t: chosen_cpu expected %0d actual %0d", $time,
						e.chosen_cpu, a.chosen_cpu);
				if (e.found != a.found)
					$display("%0t: found expected %0d actual %0d", $time,
						e.found, a.found);
				if (e.top_task != a.top_task)
					$display("%0t: top_task expected %0d actual %0d", $time,
						e.top_task, a.top_task);
				if (e.top_priority != a.top_priority)
					$display("%0t: top_priority expected %0d actual %0d", $time,
						e.top_priority, a.top_priority);
				if (e.status != a.status)
					$display("%0t: status expected %0d actual %0d", $time,
						e.status, a.status);
				if (e.ready_total != a.ready_total)
					$display("%0t: ready_total expected %0d actual %0d", $time,
						e.ready_total, a.ready_total);
				if (e != a)
					errors++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clear_model();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_no_idling();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
